@@ design/mwf_pkg.sv @@
// ----------------------------------------------------------------------------
// mwf_pkg
// Shared constants, types and codes of the median window filter.
// ----------------------------------------------------------------------------
package mwf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_KERNEL = 10;
  localparam int RING_ROWS  = MAX_KERNEL + 1;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int RING_W    = $clog2(RING_ROWS);
  localparam int LS_AW     = RING_W + COL_W;
  localparam int LS_DEPTH  = RING_ROWS * MAX_WIDTH;
  localparam int KW        = $clog2(MAX_KERNEL + 1);
  localparam int NW        = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int PIX_W     = 8;
  localparam int PLANE_W   = 3;

  localparam int WREG_W    = 11;
  localparam int HREG_W    = 13;
  localparam int KREG_W    = 4;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_KERNEL = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_TAIL,
    S_PLANE,
    S_OUT
  } state_t;

  // Raster status handed from the counter block to the controller.
  typedef struct packed {
    logic              emit;
    logic              fend;
    logic              wr_ok;
    logic [LS_AW-1:0]  wr_addr;
    logic [RING_W-1:0] ring_lo;
    logic [COL_W-1:0]  clo;
    logic [COL_W-1:0]  chi;
    logic [KW-1:0]     nrows;
    logic [NW-1:0]     n;
  } win_t;

endpackage

@@ design/mwf_if.sv @@
// ----------------------------------------------------------------------------
// mwf_in_if / mwf_out_if
// Valid/ready channels for pixel requests and filtered results.
// ----------------------------------------------------------------------------
interface mwf_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] pixel;
  modport source (output valid, output cmd, output pixel, input ready);
  modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

interface mwf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_pixel;
  logic       frame_end;
  modport source (output valid, output out_pixel, output frame_end, input ready);
  modport sink   (input valid, input out_pixel, input frame_end, output ready);
endinterface

@@ design/median_window_filter.sv @@
// A request that gives no result frees the input again after S_CHECK;
// otherwise eight bit-plane passes (S_SCAN, S_TAIL, S_PLANE) resolve the
// result before S_OUT offers it, each pass reading the cropped window once
// through the single line store read port. One request is taken at a time.
// Reset (synchronous, active low) restores 512 x 512 with a 3 x 3 window and
// restarts the frame; line store contents are left as they are.
// ----------------------------------------------------------------------------
// median_window_filter
// Streaming 2-D median filter over raster pixels, with a ring line store and
// a bit-plane rank selection.
// ----------------------------------------------------------------------------
module median_window_filter
  import mwf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  mwf_in_if.sink               in_ch,
  mwf_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  state_t state_r, state_nxt;
  win_t   win, win_r;

  logic [RING_W-1:0]  ring_r;
  logic [COL_W-1:0]   col_r;
  logic [KW-1:0]      rows_left_r;
  logic [PLANE_W-1:0] plane_r;
  logic [PIX_W-1:0]   res_r, rd_data, mask;
  logic [NW-1:0]      t_r, cnt_r;
  logic               rd_v_r, scan_last, accept, px_store, out_adv;
  logic [LS_AW-1:0]   rd_addr;

  assign accept    = in_ch.valid && in_ch.ready;
  assign scan_last = (rows_left_r == KW'(1)) && (col_r == win_r.chi);
  assign mask      = {PIX_W{1'b1}} << plane_r;

  mwf_raster u_raster (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .px_store (px_store),
    .out_adv  (out_adv),
    .win      (win)
  );

  mwf_ram #(
    .WIDTH(PIX_W),
    .DEPTH(LS_DEPTH),
    .AW   (LS_AW)
  ) u_line_store (
    .clk  (clk),
    .we   (px_store),
    .waddr(win.wr_addr),
    .wdata(in_ch.pixel),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CHECK;
      S_CHECK: state_nxt = win.emit ? S_SCAN : S_IDLE;
      S_SCAN:  if (scan_last) state_nxt = S_TAIL;
      S_TAIL:  state_nxt = S_PLANE;
      S_PLANE: state_nxt = (plane_r == '0) ? S_OUT : S_SCAN;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready      = (state_r == S_IDLE);
    px_store         = accept && (in_ch.cmd == CMD_PIXEL) && win.wr_ok;
    out_ch.valid     = (state_r == S_OUT);
    out_ch.out_pixel = res_r;
    out_ch.frame_end = win_r.fend;
    out_adv          = (state_r == S_OUT) && out_ch.ready;
    rd_addr          = {ring_r, col_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_CHECK: begin
        win_r       <= win;
        ring_r      <= win.ring_lo;
        col_r       <= win.clo;
        rows_left_r <= win.nrows;
        plane_r     <= PLANE_W'(PIX_W - 1);
        res_r       <= '0;
        t_r         <= win.n >> 1;
        cnt_r       <= '0;
      end
      S_SCAN: begin
        if (col_r == win_r.chi) begin
          col_r       <= win_r.clo;
          rows_left_r <= rows_left_r - 1'b1;
          ring_r      <= (ring_r == RING_W'(RING_ROWS - 1)) ? '0 : ring_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      S_PLANE: begin
        // Values whose upper bits match the prefix with this bit clear rank
        // below the rest, so a target at or above their count sets this bit.
        if (t_r >= cnt_r) begin
          t_r            <= t_r - cnt_r;
          res_r[plane_r] <= 1'b1;
        end
        cnt_r       <= '0;
        plane_r     <= plane_r - 1'b1;
        ring_r      <= win_r.ring_lo;
        col_r       <= win_r.clo;
        rows_left_r <= win_r.nrows;
      end
      default: ;
    endcase
    if (rd_v_r && ((rd_data & mask) == res_r)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  a_store_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    px_store |-> (state_r == S_IDLE && in_ch.valid))
    else $error("line store written outside an accepted pixel request");

  a_check_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CHECK))
    else $error("accepted request not checked for a result");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLANE) |-> (cnt_r <= win_r.n))
    else $error("bit-plane count exceeds window size");

  a_result_after_planes: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> ($past(state_r) == S_PLANE && $past(plane_r) == '0))
    else $error("result raised before all bit planes resolved");

endmodule

@@ design/mwf_ram.sv @@
// ----------------------------------------------------------------------------
// mwf_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module mwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/mwf_raster.sv @@
// ----------------------------------------------------------------------------
// mwf_raster
// Configuration registers, input and output raster counters, and the
// window bounds of the next output.
// ----------------------------------------------------------------------------
module mwf_raster
  import mwf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 px_store,
  input  logic                 out_adv,
  output win_t                 win
);

  logic [WREG_W-1:0] w_reg_r;
  logic [HREG_W-1:0] h_reg_r;
  logic [KREG_W-1:0] k_reg_r;

  logic [HREG_W-1:0] in_row_r, out_row_r;
  logic [COL_W:0]    in_col_r, out_col_r;
  logic [RING_W-1:0] in_ring_r, out_ring_r;

  logic [COL_W:0]    w_eff, wm1, ec, clo;
  logic [COL_W+1:0]  ec_sum;
  logic [HREG_W-1:0] h_eff, hm1, er, rlo;
  logic [HREG_W:0]   er_sum;
  logic [KW-1:0]     k_eff, dk, ahead, nrows, ncols;
  logic              complete;

  always_comb begin
    if (w_reg_r == '0) w_eff = (COL_W+1)'(1);
    else if (32'(w_reg_r) > MAX_WIDTH) w_eff = (COL_W+1)'(MAX_WIDTH);
    else w_eff = (COL_W+1)'(w_reg_r);
    h_eff = (h_reg_r == '0) ? HREG_W'(1) : h_reg_r;
    if (k_reg_r == '0) k_eff = KW'(1);
    else if (32'(k_reg_r) > MAX_KERNEL) k_eff = KW'(MAX_KERNEL);
    else k_eff = KW'(k_reg_r);

    dk    = k_eff >> 1;
    ahead = k_eff - KW'(1) - dk;
    wm1   = w_eff - 1'b1;
    hm1   = h_eff - 1'b1;

    er_sum = {1'b0, out_row_r} + (HREG_W+1)'(ahead);
    er     = (er_sum > {1'b0, hm1}) ? hm1 : er_sum[HREG_W-1:0];
    ec_sum = {1'b0, out_col_r} + (COL_W+2)'(ahead);
    ec     = (ec_sum > {1'b0, wm1}) ? wm1 : ec_sum[COL_W:0];

    rlo = (out_row_r >= HREG_W'(dk)) ? out_row_r - HREG_W'(dk) : '0;
    clo = (out_col_r >= (COL_W+1)'(dk)) ? out_col_r - (COL_W+1)'(dk) : '0;
    nrows = KW'(er - rlo) + KW'(1);
    ncols = KW'(ec - clo) + KW'(1);

    // The window is complete once the input raster has passed its last pixel.
    complete = !(in_row_r < h_eff &&
                 (in_row_r < er || (in_row_r == er && in_col_r <= ec)));

    win.emit    = (out_row_r < h_eff) && complete;
    win.fend    = (out_row_r == hm1) && (out_col_r == wm1);
    win.wr_ok   = in_row_r < h_eff;
    win.wr_addr = {in_ring_r, in_col_r[COL_W-1:0]};
    if (out_row_r < HREG_W'(dk)) win.ring_lo = '0;
    else if (out_ring_r >= RING_W'(dk)) win.ring_lo = out_ring_r - RING_W'(dk);
    else win.ring_lo = out_ring_r + RING_W'(RING_ROWS) - RING_W'(dk);
    win.clo   = clo[COL_W-1:0];
    win.chi   = ec[COL_W-1:0];
    win.nrows = nrows;
    win.n     = NW'(nrows) * NW'(ncols);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_reg_r <= WREG_W'(512);
      h_reg_r <= HREG_W'(512);
      k_reg_r <= KREG_W'(3);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WIDTH:  w_reg_r <= cfg_wdata[WREG_W-1:0];
        CFG_HEIGHT: h_reg_r <= cfg_wdata[HREG_W-1:0];
        CFG_KERNEL: k_reg_r <= cfg_wdata[KREG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_we && (cfg_idx == CFG_WIDTH || cfg_idx == CFG_HEIGHT ||
                              cfg_idx == CFG_KERNEL))) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      in_ring_r  <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      out_ring_r <= '0;
    end else if (px_store) begin
      if (in_col_r + 1'b1 >= w_eff) begin
        in_col_r  <= '0;
        in_row_r  <= in_row_r + 1'b1;
        in_ring_r <= (in_ring_r == RING_W'(RING_ROWS - 1)) ? '0 : in_ring_r + 1'b1;
      end else begin
        in_col_r <= in_col_r + 1'b1;
      end
    end else if (out_adv) begin
      if (win.fend) begin
        in_row_r   <= '0;
        in_col_r   <= '0;
        in_ring_r  <= '0;
        out_row_r  <= '0;
        out_col_r  <= '0;
        out_ring_r <= '0;
      end else if (out_col_r + 1'b1 >= w_eff) begin
        out_col_r  <= '0;
        out_row_r  <= out_row_r + 1'b1;
        out_ring_r <= (out_ring_r == RING_W'(RING_ROWS - 1)) ? '0 : out_ring_r + 1'b1;
      end else begin
        out_col_r <= out_col_r + 1'b1;
      end
    end
  end

endmodule
